FILE: design/ssmm_pkg.sv
// Shared constants, codes and types of the stack with running sum, maximum and minimum.
package ssmm_pkg;

  localparam int STACK_DEPTH = 1024;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int WORD_W      = 32;
  localparam int SUM_W       = 42;
  localparam int CMD_W       = 2;
  localparam int STATUS_W    = 2;
  localparam int OUT_DATA_W  = 144;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    ST_IDLE,
    ST_REFILL
  } state_t;

  typedef struct packed {
    logic [WORD_W-1:0] smallest;
    logic [WORD_W-1:0] largest;
    logic [SUM_W-1:0]  total;
    logic [WORD_W-1:0] word;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

FILE: design/ssmm_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
module ssmm_ram #(
  parameter int DEPTH  = 1024,
  parameter int WIDTH  = 8,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/stack_with_sum_min_max.sv
// Top level of the bounded stack with running sum, maximum and minimum.
// Commands arrive on the slave stream (command in s_tuser, value in s_tdata) and each one
// gives exactly one result on the master stream (status in m_tuser, payload in m_tdata).
// The top entry lives in registers and the entries beneath it in a 1024-entry RAM, each
// entry holding its word and the sum, maximum and minimum of itself and all below. Push,
// query, clear, a pop on an empty stack and a pop of the last entry need no refill; a pop
// that leaves entries behind enters a refill state, since the new top is fetched through
// the registered RAM read port. A single result register holds each result; outside a
// refill, the next command enters when no result is waiting or in the cycle the waiting
// result is taken. No clearing pass follows reset: only written entries are read.
module stack_with_sum_min_max (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [ssmm_pkg::WORD_W-1:0]        s_tdata,   // value
  input  logic [ssmm_pkg::CMD_W-1:0]         s_tuser,   // command
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [ssmm_pkg::OUT_DATA_W-1:0]    m_tdata,   // popped, total, largest, smallest, zero pad
  output logic [ssmm_pkg::STATUS_W-1:0]      m_tuser    // status
);

  ssmm_pkg::state_t state, state_next;
  logic [ssmm_pkg::CNT_W-1:0] count, count_next;
  ssmm_pkg::entry_t top, top_next, rd_entry;
  logic [ssmm_pkg::ENTRY_W-1:0] rdata;

  logic idle_ready;
  logic s_fire;
  logic refill_go;
  logic we, re;
  logic [ssmm_pkg::ADDR_W-1:0] waddr, raddr;

  ssmm_pkg::status_t res_status;
  logic [ssmm_pkg::WORD_W-1:0] res_popped, res_largest, res_smallest;
  logic [ssmm_pkg::SUM_W-1:0]  res_total;
  logic [ssmm_pkg::SUM_W-1:0]  value_ext;

  assign s_fire    = s_tvalid && s_tready;
  assign rd_entry  = ssmm_pkg::entry_t'(rdata);
  assign value_ext = {{(ssmm_pkg::SUM_W - ssmm_pkg::WORD_W){s_tdata[ssmm_pkg::WORD_W-1]}},
                      s_tdata};
  assign waddr     = ssmm_pkg::ADDR_W'(count - ssmm_pkg::CNT_W'(1));
  assign raddr     = ssmm_pkg::ADDR_W'(count - ssmm_pkg::CNT_W'(2));

  ssmm_ram #(
    .DEPTH (ssmm_pkg::STACK_DEPTH),
    .WIDTH (ssmm_pkg::ENTRY_W)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (top),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ssmm_pkg::ST_IDLE: begin
        if (refill_go) begin
          state_next = ssmm_pkg::ST_REFILL;
        end
      end
      ssmm_pkg::ST_REFILL: begin
        state_next = ssmm_pkg::ST_IDLE;
      end
      default: begin
        state_next = ssmm_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    idle_ready = 1'b0;
    unique case (state)
      ssmm_pkg::ST_IDLE:   idle_ready = 1'b1;
      ssmm_pkg::ST_REFILL: idle_ready = 1'b0;
      default:             idle_ready = 1'b0;
    endcase
  end

  assign s_tready = idle_ready && (!m_tvalid || m_tready);

  always_comb begin
    count_next   = count;
    top_next     = top;
    we           = 1'b0;
    re           = 1'b0;
    refill_go    = 1'b0;
    res_status   = ssmm_pkg::STATUS_OK;
    res_popped   = '0;
    res_total    = '0;
    res_largest  = '0;
    res_smallest = '0;
    if (state == ssmm_pkg::ST_REFILL) begin
      top_next = rd_entry;
    end
    if (s_fire) begin
      unique case (ssmm_pkg::cmd_t'(s_tuser))
        ssmm_pkg::CMD_PUSH: begin
          if (count == ssmm_pkg::CNT_W'(ssmm_pkg::STACK_DEPTH)) begin
            res_status = ssmm_pkg::STATUS_FULL;
          end else begin
            count_next    = count + ssmm_pkg::CNT_W'(1);
            top_next.word = s_tdata;
            if (count == '0) begin
              top_next.total    = value_ext;
              top_next.largest  = s_tdata;
              top_next.smallest = s_tdata;
            end else begin
              we                = 1'b1;
              top_next.total    = top.total + value_ext;
              top_next.largest  = ($signed(s_tdata) > $signed(top.largest)) ?
                                  s_tdata : top.largest;
              top_next.smallest = ($signed(s_tdata) < $signed(top.smallest)) ?
                                  s_tdata : top.smallest;
            end
          end
        end
        ssmm_pkg::CMD_POP: begin
          if (count == '0) begin
            res_status = ssmm_pkg::STATUS_EMPTY;
          end else begin
            res_popped = top.word;
            count_next = count - ssmm_pkg::CNT_W'(1);
            if (count > ssmm_pkg::CNT_W'(1)) begin
              re        = 1'b1;
              refill_go = 1'b1;
            end
          end
        end
        ssmm_pkg::CMD_QUERY: begin
          if (count == '0) begin
            res_status = ssmm_pkg::STATUS_EMPTY;
          end else begin
            res_total    = top.total;
            res_largest  = top.largest;
            res_smallest = top.smallest;
          end
        end
        ssmm_pkg::CMD_CLEAR: begin
          count_next = '0;
        end
        default: begin
          count_next = count;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ssmm_pkg::ST_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (s_fire) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    top <= top_next;
    if (s_fire) begin
      m_tuser <= res_status;
      m_tdata <= {{(ssmm_pkg::OUT_DATA_W - ssmm_pkg::ENTRY_W){1'b0}},
                  res_smallest, res_largest, res_total, res_popped};
    end
  end

endmodule

FILE: design/ssmm_checker.sv
// Port-level assertions for the stack with running sum, maximum and minimum, and their bind.
module ssmm_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic [ssmm_pkg::CMD_W-1:0]      s_tuser,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [ssmm_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic [ssmm_pkg::STATUS_W-1:0]   m_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> m_tvalid)
    else $error("transfer in gave no result");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser != 2'd3)
    else $error("undefined status code");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != ssmm_pkg::STATUS_OK |-> m_tdata == '0)
    else $error("failed command carries payload");

  a_clear_then_query: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == ssmm_pkg::CMD_CLEAR ##1
    s_tvalid && s_tready && s_tuser == ssmm_pkg::CMD_QUERY |=>
    m_tuser == ssmm_pkg::STATUS_EMPTY)
    else $error("query after clear not empty");

endmodule

bind stack_with_sum_min_max ssmm_checker u_ssmm_checker (.*);

FILE: verif/stack_with_sum_min_max_tb.sv
// Testbench for the stack with running sum, maximum and minimum: directed, pressure, full stack, random.
module stack_with_sum_min_max_tb;
  import ssmm_pkg::*;

  localparam int MAX_GAP        = 18;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int RANDOM_ITEMS   = 700;

  localparam logic [WORD_W-1:0] WORD_MAX = 32'h7fff_ffff;
  localparam logic [WORD_W-1:0] WORD_MIN = 32'h8000_0000;

  typedef struct {
    status_t           status;
    logic [WORD_W-1:0] popped;
    logic [SUM_W-1:0]  total;
    logic [WORD_W-1:0] largest;
    logic [WORD_W-1:0] smallest;
  } stack_result_t;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [WORD_W-1:0]     s_tdata;    // value
  logic [CMD_W-1:0]      s_tuser;    // command
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;    // popped, total, largest, smallest, zero pad
  logic [STATUS_W-1:0]   m_tuser;    // status

  stack_with_sum_min_max dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // Shadow stack
  logic [WORD_W-1:0] shadow_word [STACK_DEPTH];
  logic [SUM_W-1:0]  shadow_sum  [STACK_DEPTH];
  logic [WORD_W-1:0] shadow_max  [STACK_DEPTH];
  logic [WORD_W-1:0] shadow_min  [STACK_DEPTH];
  int unsigned       shadow_fill = 0;

  stack_result_t pending_results[$];

  bit tx_gaps = 1'b0;
  bit rx_gaps = 1'b0;
  int rx_hold = 0;

  int mismatches   = 0;
  int results_seen = 0;
  int n_push = 0, n_push_full = 0, n_pop = 0, n_pop_empty = 0;
  int n_query = 0, n_query_empty = 0, n_clear = 0;
  int deepest = 0;
  int idle_cycles = 0;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic stack_result_t stack_predict(cmd_t cmd, logic [WORD_W-1:0] value);
    stack_result_t     r;
    int unsigned       i;
    logic [ADDR_W-1:0] idx, below;
    logic [SUM_W-1:0]  wide;
    r.status   = STATUS_OK;
    r.popped   = '0;
    r.total    = '0;
    r.largest  = '0;
    r.smallest = '0;
    wide = {{(SUM_W-WORD_W){value[WORD_W-1]}}, value};
    case (cmd)
      CMD_PUSH: begin
        n_push++;
        if (shadow_fill >= STACK_DEPTH) begin
          r.status = STATUS_FULL;
          n_push_full++;
        end else begin
          i = shadow_fill;
          idx = ADDR_W'(i);
          below = ADDR_W'(i - 1);
          shadow_word[idx] = value;
          if (i == 0) begin
            shadow_sum[idx] = wide;
            shadow_max[idx] = value;
            shadow_min[idx] = value;
          end else begin
            shadow_sum[idx] = shadow_sum[below] + wide;
            shadow_max[idx] = ($signed(value) > $signed(shadow_max[below])) ?
                              value : shadow_max[below];
            shadow_min[idx] = ($signed(value) < $signed(shadow_min[below])) ?
                              value : shadow_min[below];
          end
          shadow_fill = i + 1;
          if (shadow_fill > deepest) deepest = shadow_fill;
        end
      end
      CMD_POP: begin
        n_pop++;
        if (shadow_fill == 0) begin
          r.status = STATUS_EMPTY;
          n_pop_empty++;
        end else begin
          shadow_fill--;
          idx = ADDR_W'(shadow_fill);
          r.popped = shadow_word[idx];
        end
      end
      CMD_QUERY: begin
        n_query++;
        if (shadow_fill == 0) begin
          r.status = STATUS_EMPTY;
          n_query_empty++;
        end else begin
          idx = ADDR_W'(shadow_fill - 1);
          r.total    = shadow_sum[idx];
          r.largest  = shadow_max[idx];
          r.smallest = shadow_min[idx];
        end
      end
      default: begin
        n_clear++;
        shadow_fill = 0;
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("result %0d: %s is %0h, expected %0h", results_seen, field, got, want);
    mismatches++;
  endtask

  // Compare each result transfer against the oldest prediction, then predict the new command
  always @(posedge clk) begin : scoreboard
    stack_result_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result, status", 64'(m_tuser), '0);
        end else begin
          want = pending_results.pop_front();
          if (m_tuser !== want.status)
            report_mismatch("status", 64'(m_tuser), 64'(want.status));
          if (m_tdata[31:0] !== want.popped)
            report_mismatch("popped", 64'(m_tdata[31:0]), 64'(want.popped));
          if (m_tdata[73:32] !== want.total)
            report_mismatch("total", 64'(m_tdata[73:32]), 64'(want.total));
          if (m_tdata[105:74] !== want.largest)
            report_mismatch("largest", 64'(m_tdata[105:74]), 64'(want.largest));
          if (m_tdata[137:106] !== want.smallest)
            report_mismatch("smallest", 64'(m_tdata[137:106]), 64'(want.smallest));
        end
      end
      if (s_tvalid && s_tready)
        pending_results.push_back(stack_predict(cmd_t'(s_tuser), s_tdata));
    end
  end

  // Watchdog on transfers
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("no transfer for %0d cycles, %0d results pending",
               idle_cycles, pending_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: random stall before each result with gaps on, or hold off for a long stretch on request
  initial begin : receiver
    int n;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) n = rx_hold;
      else n = rx_gaps ? $urandom_range(0, MAX_GAP) : 0;
      rx_hold = 0;
      if (n > 0) begin
        m_tready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!(m_tvalid && m_tready));
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer
  task automatic send_cmd(input cmd_t cmd, input logic [WORD_W-1:0] value);
    int n;
    n = tx_gaps ? $urandom_range(0, MAX_GAP) : 0;
    if (n > 0) begin
      s_tvalid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= value;
    do @(posedge clk); while (!(s_tvalid && s_tready));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return WORD_MAX;
      1:       return WORD_MIN;
      2:       return '0;
      3:       return '1;
      4, 5:    return WORD_W'($urandom_range(0, 200)) - WORD_W'(100);
      default: return $urandom;
    endcase
  endfunction

  task automatic pick_gap_mode();
    tx_gaps = 1'($urandom_range(0, 1));
    rx_gaps = 1'($urandom_range(0, 1));
  endtask

  task automatic test_directed();
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    send_cmd(CMD_POP,   '0);
    send_cmd(CMD_QUERY, '0);
    send_cmd(CMD_PUSH,  WORD_MAX);
    send_cmd(CMD_QUERY, '0);
    send_cmd(CMD_PUSH,  WORD_MIN);
    send_cmd(CMD_QUERY, '0);
    send_cmd(CMD_PUSH,  '0);
    send_cmd(CMD_PUSH,  '1);
    send_cmd(CMD_QUERY, '0);
    send_cmd(CMD_POP,   32'hdead_beef);
    send_cmd(CMD_POP,   '0);
    send_cmd(CMD_QUERY, '0);
    send_cmd(CMD_POP,   '0);
    send_cmd(CMD_POP,   '0);
    send_cmd(CMD_POP,   '0);
    send_cmd(CMD_PUSH,  32'd5);
    send_cmd(CMD_CLEAR, 32'h1234_5678);
    send_cmd(CMD_QUERY, '0);
    send_cmd(CMD_POP,   '0);
    send_cmd(CMD_PUSH,  32'd1);
    send_cmd(CMD_PUSH,  32'hffff_fffe);
    send_cmd(CMD_QUERY, '0);
    send_cmd(CMD_CLEAR, '0);
    send_cmd(CMD_CLEAR, '0);
    wait_drained();
  endtask

  task automatic test_backpressure();
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    send_cmd(CMD_PUSH, pick_word());
    rx_hold = RX_HOLD_CYCLES;
    repeat (30) send_cmd(CMD_PUSH, pick_word());
    repeat (10) begin
      send_cmd(CMD_QUERY, '0);
      send_cmd(CMD_POP, '0);
    end
    wait_drained();
    send_cmd(CMD_POP, '0);
    send_cmd(CMD_QUERY, '0);
    send_cmd(CMD_CLEAR, '0);
    wait_drained();
  endtask

  task automatic test_full_stack();
    int k;
    send_cmd(CMD_CLEAR, '0);
    for (k = 0; k < STACK_DEPTH; k++) begin
      if (k % 128 == 0) pick_gap_mode();
      send_cmd(CMD_PUSH, WORD_MAX);
    end
    send_cmd(CMD_QUERY, '0);
    repeat (3) send_cmd(CMD_PUSH, pick_word());
    send_cmd(CMD_QUERY, '0);
    repeat (20) begin
      send_cmd(CMD_POP, '0);
      send_cmd(CMD_QUERY, '0);
    end
    send_cmd(CMD_CLEAR, '0);
    send_cmd(CMD_QUERY, '0);
    wait_drained();
  endtask

  task automatic test_random();
    int  k, r;
    bit  growing;
    cmd_t cmd;
    growing = 1'b1;
    for (k = 0; k < RANDOM_ITEMS; k++) begin
      if (k % 50 == 0) begin
        pick_gap_mode();
        growing = $urandom_range(0, 2) != 0;
      end
      r = $urandom_range(0, 99);
      if (growing)
        cmd = (r < 60) ? CMD_PUSH : (r < 75) ? CMD_QUERY : (r < 98) ? CMD_POP : CMD_CLEAR;
      else
        cmd = (r < 25) ? CMD_PUSH : (r < 45) ? CMD_QUERY : (r < 99) ? CMD_POP : CMD_CLEAR;
      send_cmd(cmd, (cmd == CMD_PUSH || r % 3 == 0) ? pick_word() : WORD_W'($urandom));
    end
    wait_drained();
  endtask

  initial begin
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = CMD_PUSH;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed();
    test_backpressure();
    test_full_stack();
    test_random();

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("checked %0d results: %0d pushes (%0d refused as full), %0d pops (%0d on empty)",
             results_seen, n_push, n_push_full, n_pop, n_pop_empty);
    $display("  %0d queries (%0d on empty), %0d clears, deepest fill %0d, %0d mismatches",
             n_query, n_query_empty, n_clear, deepest, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
